// ===== rtl/plcphdr_pkg.sv =====
package plcphdr_pkg;

    localparam int OCTETS_W  = 12;
    localparam int BITRATE_W = 7;
    localparam int WORD_W    = 32;
    localparam int DIVIDEND_W = 16;
    localparam int QUOT_W    = 13;
    localparam int REM_W     = 4;

    // x / 11 == (x * DIV11_MUL) >> DIV11_SHIFT for every 16-bit x
    localparam int DIV11_MUL_W = 17;
    localparam logic [DIV11_MUL_W-1:0] DIV11_MUL = 17'd95326;
    localparam int DIV11_SHIFT = 20;
    localparam int PROD_W = DIVIDEND_W + DIV11_MUL_W;

    localparam logic [7:0] SERVICE_LOCKED = 8'h04;
    localparam logic [7:0] SERVICE_LENEXT = 8'h84;
    localparam logic [REM_W-1:0] LENEXT_LIMIT = 4'd4;

    localparam logic [7:0] SIGNAL_1M  = 8'h0A;
    localparam logic [7:0] SIGNAL_2M  = 8'h14;
    localparam logic [7:0] SIGNAL_55M = 8'h37;
    localparam logic [7:0] SIGNAL_11M = 8'h6E;

    // bitrates in 500 kbit/s units
    localparam logic [BITRATE_W-1:0] BR_1M   = 7'd2;
    localparam logic [BITRATE_W-1:0] BR_2M   = 7'd4;
    localparam logic [BITRATE_W-1:0] BR_5M5  = 7'd11;
    localparam logic [BITRATE_W-1:0] BR_11M  = 7'd22;
    localparam logic [BITRATE_W-1:0] BR_6M   = 7'd12;
    localparam logic [BITRATE_W-1:0] BR_9M   = 7'd18;
    localparam logic [BITRATE_W-1:0] BR_12M  = 7'd24;
    localparam logic [BITRATE_W-1:0] BR_18M  = 7'd36;
    localparam logic [BITRATE_W-1:0] BR_24M  = 7'd48;
    localparam logic [BITRATE_W-1:0] BR_36M  = 7'd72;
    localparam logic [BITRATE_W-1:0] BR_48M  = 7'd96;
    localparam logic [BITRATE_W-1:0] BR_54M  = 7'd108;

    // OFDM rate codes
    localparam logic [3:0] CODE_6M  = 4'hB;
    localparam logic [3:0] CODE_9M  = 4'hF;
    localparam logic [3:0] CODE_12M = 4'hA;
    localparam logic [3:0] CODE_18M = 4'hE;
    localparam logic [3:0] CODE_24M = 4'h9;
    localparam logic [3:0] CODE_36M = 4'hD;
    localparam logic [3:0] CODE_48M = 4'h8;
    localparam logic [3:0] CODE_54M = 4'hC;

    typedef enum logic [2:0] {
        RATE_NONE,
        RATE_GRP_OFDM,
        RATE_CCK1,
        RATE_CCK2,
        RATE_CCK55,
        RATE_CCK11
    } rate_class_t;

    typedef struct packed {
        rate_class_t                rclass;
        logic [7:0]                 code;
    } rate_info_t;

    // after decode
    typedef struct packed {
        rate_class_t                rclass;
        logic [7:0]                 code;
        logic [OCTETS_W-1:0]        octets;
        logic [DIVIDEND_W-1:0]      dividend;
    } dec_stage_t;

    // after the reciprocal multiply
    typedef struct packed {
        rate_class_t                rclass;
        logic [7:0]                 code;
        logic [OCTETS_W-1:0]        octets;
        logic [DIVIDEND_W-1:0]      dividend;
        logic [QUOT_W-1:0]          quot;
    } div_stage_t;

    function automatic rate_info_t decode_rate(input logic [BITRATE_W-1:0] bitrate);
        rate_info_t info;
        info.rclass = RATE_NONE;
        info.code   = 8'h00;
        unique case (bitrate)
            BR_6M:   begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_6M};  end
            BR_9M:   begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_9M};  end
            BR_12M:  begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_12M}; end
            BR_18M:  begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_18M}; end
            BR_24M:  begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_24M}; end
            BR_36M:  begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_36M}; end
            BR_48M:  begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_48M}; end
            BR_54M:  begin info.rclass = RATE_GRP_OFDM; info.code = {4'h0, CODE_54M}; end
            BR_1M:   begin info.rclass = RATE_CCK1;     info.code = SIGNAL_1M;        end
            BR_2M:   begin info.rclass = RATE_CCK2;     info.code = SIGNAL_2M;        end
            BR_5M5:  begin info.rclass = RATE_CCK55;    info.code = SIGNAL_55M;       end
            BR_11M:  begin info.rclass = RATE_CCK11;    info.code = SIGNAL_11M;       end
            default: begin info.rclass = RATE_NONE;     info.code = 8'h00;            end
        endcase
        return info;
    endfunction

endpackage

// ===== rtl/plcphdr_in_if.sv =====
interface plcphdr_in_if;
    logic                               valid;
    logic                               ready;
    logic [plcphdr_pkg::OCTETS_W-1:0]   octets;
    logic [plcphdr_pkg::BITRATE_W-1:0]  bitrate;

    modport source (output valid, output octets, output bitrate, input ready);
    modport sink   (input valid, input octets, input bitrate, output ready);
endinterface

// ===== rtl/plcphdr_out_if.sv =====
interface plcphdr_out_if;
    logic                               valid;
    logic                               ready;
    logic [plcphdr_pkg::WORD_W-1:0]     plcp_word;
    logic                               is_ofdm;
    logic                               rate_valid;

    modport source (output valid, output plcp_word, output is_ofdm, output rate_valid,
                    input ready);
    modport sink   (input valid, input plcp_word, input is_ofdm, input rate_valid,
                    output ready);
endinterface

// ===== rtl/plcphdr_decode.sv =====
module plcphdr_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    plcphdr_in_if.sink              req,
    output plcphdr_pkg::dec_stage_t dec,
    output logic                    dec_valid,
    input  logic                    dec_ready
);

    plcphdr_pkg::dec_stage_t dec_reg;
    plcphdr_pkg::dec_stage_t dec_next;
    logic                    valid_reg;
    plcphdr_pkg::rate_info_t info;
    logic                    load;

    assign req.ready = !valid_reg || dec_ready;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        info = plcphdr_pkg::decode_rate(req.bitrate);
        dec_next.rclass = info.rclass;
        dec_next.code   = info.code;
        dec_next.octets = req.octets;
        // 5.5M divides octets*16 by 11, 11M divides octets*8 by 11
        if (info.rclass == plcphdr_pkg::RATE_CCK11)
        begin
            dec_next.dividend = {1'b0, req.octets, 3'b000};
        end
        else
        begin
            dec_next.dividend = {req.octets, 4'b0000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec       = dec_reg;
    assign dec_valid = valid_reg;

endmodule

// ===== rtl/plcphdr_div11.sv =====
module plcphdr_div11 (
    input  logic                    clk,
    input  logic                    rst_n,
    input  plcphdr_pkg::dec_stage_t dec,
    input  logic                    dec_valid,
    output logic                    dec_ready,
    output plcphdr_pkg::div_stage_t div,
    output logic                    div_valid,
    input  logic                    div_ready
);

    plcphdr_pkg::div_stage_t div_reg;
    plcphdr_pkg::div_stage_t div_next;
    logic                    valid_reg;
    logic [plcphdr_pkg::PROD_W-1:0] product;

    assign dec_ready = !valid_reg || div_ready;

    always_comb
    begin
        product = {{plcphdr_pkg::DIV11_MUL_W{1'b0}}, dec.dividend}
                * {{plcphdr_pkg::DIVIDEND_W{1'b0}}, plcphdr_pkg::DIV11_MUL};
        div_next.rclass   = dec.rclass;
        div_next.code     = dec.code;
        div_next.octets   = dec.octets;
        div_next.dividend = dec.dividend;
        div_next.quot     = product[plcphdr_pkg::DIV11_SHIFT +: plcphdr_pkg::QUOT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (dec_ready)
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_valid && dec_ready)
        begin
            div_reg <= div_next;
        end
    end

    assign div       = div_reg;
    assign div_valid = valid_reg;

endmodule

// ===== rtl/plcphdr_assemble.sv =====
module plcphdr_assemble (
    input  logic                    clk,
    input  logic                    rst_n,
    input  plcphdr_pkg::div_stage_t div,
    input  logic                    div_valid,
    output logic                    div_ready,
    plcphdr_out_if.source           rsp
);

    logic                              valid_reg;
    logic [plcphdr_pkg::WORD_W-1:0]    word_reg;
    logic [plcphdr_pkg::WORD_W-1:0]    word_next;
    logic                              ofdm_reg;
    logic                              ofdm_next;
    logic                              rvalid_reg;
    logic                              rvalid_next;
    logic [16:0]                       quot_x11;
    logic [plcphdr_pkg::DIVIDEND_W-1:0] diff;
    logic [plcphdr_pkg::REM_W-1:0]     rem;
    logic                              rem_nz;
    logic [15:0]                       len_div;
    logic [15:0]                       len;
    logic [7:0]                        service;

    assign div_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        quot_x11 = {1'b0, div.quot, 3'b000} + {3'b000, div.quot, 1'b0} + {4'b0000, div.quot};
        diff     = div.dividend - quot_x11[plcphdr_pkg::DIVIDEND_W-1:0];
        rem      = diff[plcphdr_pkg::REM_W-1:0];
        rem_nz   = (rem != '0);
        // round up when the division leaves a remainder
        len_div  = {3'b000, div.quot} + {15'd0, rem_nz};
        service  = plcphdr_pkg::SERVICE_LOCKED;
        len      = 16'd0;
        word_next   = '0;
        ofdm_next   = 1'b0;
        rvalid_next = 1'b0;
        unique case (div.rclass)
            plcphdr_pkg::RATE_GRP_OFDM:
            begin
                word_next   = {15'd0, div.octets, 1'b0, div.code[3:0]};
                ofdm_next   = 1'b1;
                rvalid_next = 1'b1;
            end
            plcphdr_pkg::RATE_CCK1:
            begin
                len         = {1'b0, div.octets, 3'b000};
                word_next   = {len, service, div.code};
                rvalid_next = 1'b1;
            end
            plcphdr_pkg::RATE_CCK2:
            begin
                len         = {2'b00, div.octets, 2'b00};
                word_next   = {len, service, div.code};
                rvalid_next = 1'b1;
            end
            plcphdr_pkg::RATE_CCK55:
            begin
                len         = len_div;
                word_next   = {len, service, div.code};
                rvalid_next = 1'b1;
            end
            plcphdr_pkg::RATE_CCK11:
            begin
                len = len_div;
                // length extension: small nonzero remainder at 11 Mbit/s
                if (rem_nz && (rem < plcphdr_pkg::LENEXT_LIMIT))
                begin
                    service = plcphdr_pkg::SERVICE_LENEXT;
                end
                word_next   = {len, service, div.code};
                rvalid_next = 1'b1;
            end
            default:
            begin
                word_next   = '0;
                ofdm_next   = 1'b0;
                rvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_valid && div_ready)
        begin
            word_reg   <= word_next;
            ofdm_reg   <= ofdm_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.plcp_word  = word_reg;
    assign rsp.is_ofdm    = ofdm_reg;
    assign rsp.rate_valid = rvalid_reg;

endmodule

// ===== rtl/plcp_header_rate_length_gen.sv =====
// Registered stages from request acceptance to response valid
// (decode, divide-by-11 reciprocal multiply, remainder check and assembly).
// Throughput: one request per cycle while rsp.ready is high; each stage holds under backpressure.
// Reset: asynchronous active-low rst_n clears all stage valid bits; no
// request is pending after reset and data registers are not reset.
module plcp_header_rate_length_gen (
    input  logic          clk,
    input  logic          rst_n,
    plcphdr_in_if.sink    req,
    plcphdr_out_if.source rsp
);

    plcphdr_pkg::dec_stage_t dec;
    logic                    dec_valid;
    logic                    dec_ready;
    plcphdr_pkg::div_stage_t div;
    logic                    div_valid;
    logic                    div_ready;

    plcphdr_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .dec       (dec),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready)
    );

    plcphdr_div11 u_div11 (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec       (dec),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .div       (div),
        .div_valid (div_valid),
        .div_ready (div_ready)
    );

    plcphdr_assemble u_assemble (
        .clk       (clk),
        .rst_n     (rst_n),
        .div       (div),
        .div_valid (div_valid),
        .div_ready (div_ready),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/plcphdr_checker.sv =====
module plcphdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] plcp_word,
    input logic        is_ofdm,
    input logic        rate_valid
);

    // hold a stalled response
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(plcp_word)
            && $stable(is_ofdm) && $stable(rate_valid))
    else $error("stalled response changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rate_valid |-> plcp_word == 32'd0 && !is_ofdm)
    else $error("unknown rate gave nonzero word");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_ofdm |-> rate_valid && plcp_word[31:17] == 15'd0
            && !plcp_word[4] && plcp_word[3])
    else $error("bad OFDM word layout");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rate_valid && !is_ofdm |->
            (plcp_word[7:0] == 8'h0A || plcp_word[7:0] == 8'h14
             || plcp_word[7:0] == 8'h37 || plcp_word[7:0] == 8'h6E)
            && (plcp_word[15:8] == 8'h04
                || (plcp_word[15:8] == 8'h84 && plcp_word[7:0] == 8'h6E)))
    else $error("bad CCK signal or service byte");

endmodule

bind plcp_header_rate_length_gen plcphdr_checker u_plcphdr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .plcp_word  (rsp.plcp_word),
    .is_ofdm    (rsp.is_ofdm),
    .rate_valid (rsp.rate_valid)
);

// ===== sim/tb_plcp_header_rate_length_gen.sv =====
`timescale 1ns / 1ps

module tb_plcp_header_rate_length_gen;

    localparam int OCTETS_W  = plcphdr_pkg::OCTETS_W;
    localparam int BITRATE_W = plcphdr_pkg::BITRATE_W;
    localparam int WORD_W    = plcphdr_pkg::WORD_W;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED  = 50;

    localparam logic [BITRATE_W-1:0] CCK_RATES [4] =
        '{plcphdr_pkg::BR_1M, plcphdr_pkg::BR_2M, plcphdr_pkg::BR_5M5, plcphdr_pkg::BR_11M};
    localparam logic [BITRATE_W-1:0] OFDM_RATES [8] =
        '{plcphdr_pkg::BR_6M, plcphdr_pkg::BR_9M, plcphdr_pkg::BR_12M, plcphdr_pkg::BR_18M,
          plcphdr_pkg::BR_24M, plcphdr_pkg::BR_36M, plcphdr_pkg::BR_48M, plcphdr_pkg::BR_54M};

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              ofdm;
        logic              known;
    } header_t;

    class header_checker;
        header_t expected_headers[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function header_t predict_header(logic [OCTETS_W-1:0] octets,
                                         logic [BITRATE_W-1:0] bitrate);
            header_t     h;
            logic [3:0]  code;
            logic [7:0]  signal;
            logic [7:0]  service;
            bit          ofdm_hit;
            bit          cck_hit;
            int unsigned oct;
            int unsigned bits;
            int unsigned usec;
            h        = '0;
            code     = '0;
            signal   = '0;
            ofdm_hit = 1'b1;
            cck_hit  = 1'b1;
            oct      = octets;
            unique case (bitrate)
                plcphdr_pkg::BR_6M:  code = plcphdr_pkg::CODE_6M;
                plcphdr_pkg::BR_9M:  code = plcphdr_pkg::CODE_9M;
                plcphdr_pkg::BR_12M: code = plcphdr_pkg::CODE_12M;
                plcphdr_pkg::BR_18M: code = plcphdr_pkg::CODE_18M;
                plcphdr_pkg::BR_24M: code = plcphdr_pkg::CODE_24M;
                plcphdr_pkg::BR_36M: code = plcphdr_pkg::CODE_36M;
                plcphdr_pkg::BR_48M: code = plcphdr_pkg::CODE_48M;
                plcphdr_pkg::BR_54M: code = plcphdr_pkg::CODE_54M;
                default:             ofdm_hit = 1'b0;
            endcase
            unique case (bitrate)
                plcphdr_pkg::BR_1M:  signal = plcphdr_pkg::SIGNAL_1M;
                plcphdr_pkg::BR_2M:  signal = plcphdr_pkg::SIGNAL_2M;
                plcphdr_pkg::BR_5M5: signal = plcphdr_pkg::SIGNAL_55M;
                plcphdr_pkg::BR_11M: signal = plcphdr_pkg::SIGNAL_11M;
                default:             cck_hit = 1'b0;
            endcase
            if (ofdm_hit)
            begin
                h.word  = {15'd0, octets, 1'b0, code};
                h.ofdm  = 1'b1;
                h.known = 1'b1;
            end
            else if (cck_hit)
            begin
                bits    = oct * 16;
                usec    = bits / bitrate;
                service = plcphdr_pkg::SERVICE_LOCKED;
                if (bits % bitrate != 0)
                begin
                    usec++;
                    // length extension: rounding at 11M added at least 8/11 us
                    if (bitrate == plcphdr_pkg::BR_11M
                        && (oct * 8) % 11 < plcphdr_pkg::LENEXT_LIMIT)
                        service = plcphdr_pkg::SERVICE_LENEXT;
                end
                h.word  = {usec[15:0], service, signal};
                h.known = 1'b1;
            end
            return h;
        endfunction

        function void note_request(logic [OCTETS_W-1:0] octets, logic [BITRATE_W-1:0] bitrate);
            expected_headers.push_back(predict_header(octets, bitrate));
        endfunction

        function int outstanding();
            return expected_headers.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t MISMATCH %s", $realtime, msg);
        endtask

        task check_response(logic [WORD_W-1:0] word, logic ofdm, logic known);
            header_t exp;
            if (expected_headers.size() == 0)
            begin
                report($sformatf("unexpected response word=%h", word));
                return;
            end
            exp = expected_headers.pop_front();
            if (word !== exp.word)
                report($sformatf("plcp_word got %h want %h", word, exp.word));
            if (ofdm !== exp.ofdm)
                report($sformatf("is_ofdm got %b want %b", ofdm, exp.ofdm));
            if (known !== exp.known)
                report($sformatf("rate_valid got %b want %b", known, exp.known));
        endtask

        task flag_leftovers();
            while (expected_headers.size() != 0)
            begin
                report($sformatf("missing response word=%h", expected_headers[0].word));
                void'(expected_headers.pop_front());
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   tx_idle_pct;
    int   rx_idle_pct;

    header_checker hdr_check;

    plcphdr_in_if  req_if ();
    plcphdr_out_if rsp_if ();

    plcp_header_rate_length_gen DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            hdr_check.check_response(rsp_if.plcp_word, rsp_if.is_ofdm, rsp_if.rate_valid);
    end

    task send_header(input logic [OCTETS_W-1:0] octets, input logic [BITRATE_W-1:0] bitrate);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.octets  <= octets;
        req_if.bitrate <= bitrate;
        do
            @(posedge clk);
        while (!req_if.ready);
        hdr_check.note_request(octets, bitrate);
    endtask

    function automatic logic [OCTETS_W-1:0] random_octets();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        if (sel < 10)
            return '1;
        if (sel < 20)
            return OCTETS_W'($urandom_range(0, 31));
        return OCTETS_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [BITRATE_W-1:0] random_bitrate();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return CCK_RATES[$urandom_range(0, 3)];
        if (sel < 80)
            return OFDM_RATES[$urandom_range(0, 7)];
        return BITRATE_W'($urandom_range(0, 127));
    endfunction

    task send_random(input int count);
        for (int i = 0; i < count; i++)
            send_header(random_octets(), random_bitrate());
    endtask

    initial
    begin
        hdr_check      = new();
        tx_idle_pct    = 16;
        rx_idle_pct    = 56;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.octets  = '0;
        req_if.bitrate = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every known rate at the longest frame
        foreach (CCK_RATES[i])
            send_header('1, CCK_RATES[i]);
        foreach (OFDM_RATES[i])
            send_header('1, OFDM_RATES[i]);
        send_header('0, plcphdr_pkg::BR_1M);
        send_header('0, plcphdr_pkg::BR_54M);
        // unknown rates: zero, all ones, a gap between known ones
        send_header('1, 7'd0);
        send_header('1, 7'd127);
        send_header('1, 7'd23);
        // 11M length extension edges, and exact divisions
        send_header(12'd3, plcphdr_pkg::BR_11M);
        send_header(12'd6, plcphdr_pkg::BR_11M);
        send_header(12'd7, plcphdr_pkg::BR_11M);
        send_header(12'd11, plcphdr_pkg::BR_11M);
        send_header(12'd11, plcphdr_pkg::BR_5M5);

        send_random(334);
        tx_idle_pct = 56;
        rx_idle_pct = 16;
        send_random(333);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(333);
        req_if.valid <= 1'b0;

        while (hdr_check.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        hdr_check.flag_leftovers();

        if (hdr_check.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
